// File: hdl/sshh_pkg.sv
package sshh_pkg;

   localparam int Capacity  = 64;
   localparam int SlotBits  = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int OccBits   = $clog2(Capacity + 1);
   localparam int KeyBits   = 32;
   localparam int CountBits = 32;

   localparam logic [CountBits-1:0] CountMax = '1;
   localparam logic [CountBits-1:0] CountOne = CountBits'(1);

   typedef logic [SlotBits-1:0]  slot_idx_type;
   typedef logic [OccBits-1:0]   occ_type;
   typedef logic [KeyBits-1:0]   key_type;
   typedef logic [CountBits-1:0] count_type;

   // Command codes carried on the request side
   localparam logic CmdUpdate = 1'b0;
   localparam logic CmdQuery  = 1'b1;

   // Saturating increment of a slot count
   function automatic count_type sat_inc(input count_type value);
      sat_inc = (value == CountMax) ? value : value + CountOne;
   endfunction

endpackage

// File: hdl/space_saving_heavy_hitters.sv
// Space-Saving heavy-hitter table: up to 64 monitored keys, each with a
// saturating 32-bit count. An update of a monitored key increments its count,
// a new key takes the next free slot with count 1, and once the table is full
// a new key replaces the lowest-indexed minimum-count entry, taking that
// minimum plus one; the displaced key is reported. A query returns the count
// (0 when absent) without touching the table. One transaction is handled at a
// time: the occupied slots are scanned through the single read port of the
// key/count memory, one slot per cycle by one shared compare unit (no scan
// while the table is still empty), then the table is written and the
// response is offered; req_tready stays low until the response has been taken
// and rises the cycle after.
module space_saving_heavy_hitters (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_key
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [31:0] estimate, [32] was_monitored,
                                    // [33] evicted_valid, [65:34] evicted_key,
                                    // [71:66] zero
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StScan  = 3'd1;
   localparam logic [2:0] StDrain = 3'd2;
   localparam logic [2:0] StWrite = 3'd3;
   localparam logic [2:0] StResp  = 3'd4;

   localparam sshh_pkg::occ_type OccFull = sshh_pkg::OccBits'(sshh_pkg::Capacity);
   localparam sshh_pkg::occ_type OccOne  = sshh_pkg::OccBits'(1);

   // Slot memories
   sshh_pkg::key_type   key_mem   [sshh_pkg::Capacity];
   sshh_pkg::count_type count_mem [sshh_pkg::Capacity];

   logic [2:0]             state_ff, state_in;
   sshh_pkg::occ_type      occ_ff, occ_in;
   sshh_pkg::slot_idx_type addr_ff, addr_in;
   logic                   cmd_ff, cmd_in;
   sshh_pkg::key_type      key_ff, key_in;

   // Registered memory read
   logic                   rd_vld_ff;
   sshh_pkg::slot_idx_type rd_idx_ff;
   sshh_pkg::key_type      rd_key_ff;
   sshh_pkg::count_type    rd_cnt_ff;

   // Scan results
   logic                   hit_ff, hit_in;
   sshh_pkg::slot_idx_type hit_idx_ff, hit_idx_in;
   sshh_pkg::count_type    hit_cnt_ff, hit_cnt_in;
   sshh_pkg::slot_idx_type min_idx_ff, min_idx_in;
   sshh_pkg::count_type    min_cnt_ff, min_cnt_in;
   sshh_pkg::key_type      min_key_ff, min_key_in;

   // Response register
   sshh_pkg::count_type    est_ff, est_in;
   logic                   mon_ff, mon_in;
   logic                   ev_vld_ff, ev_vld_in;
   sshh_pkg::key_type      ev_key_ff, ev_key_in;

   // Memory write port
   logic                   wr_key_en, wr_cnt_en;
   sshh_pkg::slot_idx_type wr_addr;
   sshh_pkg::count_type    wr_cnt;
   sshh_pkg::count_type    new_cnt;

   logic                   accept;
   logic                   rd_en;
   logic                   last_addr;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StResp);
   assign rsp_tdata  = {6'd0, ev_key_ff, ev_vld_ff, mon_ff, est_ff};
   assign rd_en      = (state_ff == StScan);
   assign last_addr  = ({1'b0, addr_ff} == (occ_ff - OccOne));

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (wr_cnt_en) begin
         count_mem[wr_addr] <= wr_cnt;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[addr_ff];
         rd_cnt_ff <= count_mem[addr_ff];
         rd_idx_ff <= addr_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      addr_in    = addr_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_cnt_in = hit_cnt_ff;
      min_idx_in = min_idx_ff;
      min_cnt_in = min_cnt_ff;
      min_key_in = min_key_ff;
      est_in     = est_ff;
      mon_in     = mon_ff;
      ev_vld_in  = ev_vld_ff;
      ev_key_in  = ev_key_ff;
      wr_key_en  = 1'b0;
      wr_cnt_en  = 1'b0;
      wr_addr    = min_idx_ff;
      wr_cnt     = sshh_pkg::CountOne;
      new_cnt    = sshh_pkg::sat_inc(hit_cnt_ff);

      // Shared compare unit: one slot per cycle
      if (rd_vld_ff) begin
         if (!hit_ff && (rd_key_ff == key_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_cnt_in = rd_cnt_ff;
         end
         if ((rd_idx_ff == '0) || (rd_cnt_ff < min_cnt_ff)) begin
            min_idx_in = rd_idx_ff;
            min_cnt_in = rd_cnt_ff;
            min_key_in = rd_key_ff;
         end
      end

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd_in  = req_tuser;
               key_in  = req_tdata[sshh_pkg::KeyBits-1:0];
               hit_in  = 1'b0;
               addr_in = '0;
               state_in = (occ_ff == '0) ? StWrite : StScan;
            end
         end
         StScan: begin
            if (last_addr) begin
               state_in = StDrain;
            end else begin
               addr_in = addr_ff + sshh_pkg::SlotBits'(1);
            end
         end
         StDrain: begin
            state_in = StWrite;
         end
         StWrite: begin
            mon_in    = hit_ff;
            ev_vld_in = 1'b0;
            ev_key_in = '0;
            if (cmd_ff == sshh_pkg::CmdQuery) begin
               est_in = hit_ff ? hit_cnt_ff : '0;
            end else if (hit_ff) begin
               wr_cnt_en = 1'b1;
               wr_addr   = hit_idx_ff;
               wr_cnt    = new_cnt;
               est_in    = new_cnt;
            end else if (occ_ff != OccFull) begin
               // Fill the next free slot
               wr_key_en = 1'b1;
               wr_cnt_en = 1'b1;
               wr_addr   = occ_ff[sshh_pkg::SlotBits-1:0];
               wr_cnt    = sshh_pkg::CountOne;
               est_in    = sshh_pkg::CountOne;
               occ_in    = occ_ff + OccOne;
            end else begin
               // Replace the minimum entry
               wr_key_en = 1'b1;
               wr_cnt_en = 1'b1;
               wr_addr   = min_idx_ff;
               wr_cnt    = sshh_pkg::sat_inc(min_cnt_ff);
               est_in    = sshh_pkg::sat_inc(min_cnt_ff);
               ev_vld_in = 1'b1;
               ev_key_in = min_key_ff;
            end
            state_in = StResp;
         end
         StResp: begin
            if (rsp_tready) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         occ_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_cnt_ff <= hit_cnt_in;
      min_idx_ff <= min_idx_in;
      min_cnt_ff <= min_cnt_in;
      min_key_ff <= min_key_in;
      est_ff     <= est_in;
      mon_ff     <= mon_in;
      ev_vld_ff  <= ev_vld_in;
      ev_key_ff  <= ev_key_in;
   end

endmodule
